FILE: hw/rtl/json_string_utf8_unescape_top_assert.svh
`ifndef JSON_STRING_UTF8_UNESCAPE_TOP_ASSERT_SVH
`define JSON_STRING_UTF8_UNESCAPE_TOP_ASSERT_SVH

// checked only out of reset
`define JSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESCAPE = 3'd1;
   localparam logic [2:0] MODE_HEX    = 3'd2;
   localparam logic [2:0] MODE_UTF8   = 3'd3;
   localparam logic [2:0] MODE_DONE   = 3'd4;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_ESCAPE = 3'd0;
   localparam logic [2:0] ERR_LEAD   = 3'd1;
   localparam logic [2:0] ERR_CONT   = 3'd2;
   localparam logic [2:0] ERR_VALUE  = 3'd3;
   localparam logic [2:0] ERR_UNTERM = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [20:0] code_point;
      logic [2:0]  error_code;
      logic        final_flag;
   } rsp_type;

   // one accepted byte: an optional result, then an optional unterminated error
   typedef struct packed {
      logic    first_valid;
      logic    unterm;
      rsp_type first;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   localparam rsp_type UNTERM_RSP = '{
      kind: KIND_ERROR, code_point: 21'd0, error_code: ERR_UNTERM, final_flag: 1'b1
   };

endpackage

FILE: hw/rtl/jsu_front.sv
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  jsu_pkg::req_type   req_data,
   output logic               push,
   output jsu_pkg::entry_type entry
);
   import jsu_pkg::*;

   logic [2:0]  mode_ff, mode_in;
   logic [20:0] acc_ff, acc_in;
   logic [2:0]  remain_ff, remain_in;
   logic [16:0] min_ff, min_in;

   logic [7:0]  b;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [20:0] acc_hex;
   logic [20:0] acc_utf;
   logic [2:0]  remain_dec;
   logic        value_bad;

   assign b          = req_data.byte_in;
   assign acc_hex    = {acc_ff[16:0], hex_val};
   assign acc_utf    = {acc_ff[14:0], b[5:0]};
   assign remain_dec = remain_ff - 3'd1;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_val = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         hex_val = b[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      value_bad = (acc_utf[15:1] == 15'h7fff)
               || (acc_utf[20:4] == 17'h00fdd)
               || (acc_utf >= 21'h110000)
               || (acc_utf < {4'd0, min_ff})
               || (acc_utf >= 21'h00d800 && acc_utf <= 21'h00dfff);
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;
      min_in    = min_ff;
      entry.first_valid      = 1'b0;
      entry.first.kind       = KIND_CHAR;
      entry.first.code_point = 21'd0;
      entry.first.error_code = ERR_ESCAPE;
      entry.first.final_flag = 1'b0;

      unique case (mode_ff)
         MODE_DONE: begin
         end
         MODE_ESCAPE: begin
            mode_in = MODE_NORMAL;
            entry.first_valid = 1'b1;
            case (b)
               8'h62: entry.first.code_point = 21'h08;
               8'h66: entry.first.code_point = 21'h0c;
               8'h6e: entry.first.code_point = 21'h0a;
               8'h72: entry.first.code_point = 21'h0d;
               8'h74: entry.first.code_point = 21'h09;
               8'h75: begin
                  entry.first_valid = 1'b0;
                  mode_in   = MODE_HEX;
                  acc_in    = 21'd0;
                  remain_in = 3'd4;
               end
               default: entry.first.code_point = {13'd0, b};
            endcase
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               entry.first_valid      = 1'b1;
               entry.first.kind       = KIND_ERROR;
               entry.first.error_code = ERR_ESCAPE;
               entry.first.final_flag = 1'b1;
               mode_in = MODE_DONE;
            end else begin
               acc_in    = acc_hex;
               remain_in = remain_dec;
               if (remain_dec == 3'd0) begin
                  entry.first_valid      = 1'b1;
                  entry.first.code_point = acc_hex;
                  mode_in = MODE_NORMAL;
               end
            end
         end
         MODE_UTF8: begin
            if (b[7:6] != 2'b10) begin
               entry.first_valid      = 1'b1;
               entry.first.kind       = KIND_ERROR;
               entry.first.error_code = ERR_CONT;
               entry.first.final_flag = 1'b1;
               mode_in = MODE_DONE;
            end else begin
               acc_in    = acc_utf;
               remain_in = remain_dec;
               if (remain_dec == 3'd0) begin
                  entry.first_valid = 1'b1;
                  if (value_bad) begin
                     entry.first.kind       = KIND_ERROR;
                     entry.first.error_code = ERR_VALUE;
                     entry.first.final_flag = 1'b1;
                     mode_in = MODE_DONE;
                  end else begin
                     entry.first.code_point = acc_utf;
                     mode_in = MODE_NORMAL;
                  end
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (b == 8'h22) begin
               entry.first_valid      = 1'b1;
               entry.first.kind       = KIND_CLOSE;
               entry.first.final_flag = 1'b1;
               mode_in = MODE_DONE;
            end else if (b == 8'h5c) begin
               mode_in = MODE_ESCAPE;
            end else if (!b[7]) begin
               entry.first_valid      = 1'b1;
               entry.first.code_point = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
               acc_in    = {16'd0, b[4:0]};
               remain_in = 3'd1;
               min_in    = 17'h00080;
               mode_in   = MODE_UTF8;
            end else if (b[7:4] == 4'b1110) begin
               acc_in    = {17'd0, b[3:0]};
               remain_in = 3'd2;
               min_in    = 17'h00800;
               mode_in   = MODE_UTF8;
            end else if (b[7:3] == 5'b11110) begin
               acc_in    = {18'd0, b[2:0]};
               remain_in = 3'd3;
               min_in    = 17'h10000;
               mode_in   = MODE_UTF8;
            end else begin
               entry.first_valid      = 1'b1;
               entry.first.kind       = KIND_ERROR;
               entry.first.error_code = ERR_LEAD;
               entry.first.final_flag = 1'b1;
               mode_in = MODE_DONE;
            end
         end
      endcase

      entry.unterm = req_data.last_byte && (mode_in != MODE_DONE);

      // end of buffer: back to the reset state
      if (req_data.last_byte) begin
         mode_in   = MODE_NORMAL;
         acc_in    = 21'd0;
         remain_in = 3'd0;
         min_in    = 17'd0;
      end
   end

   assign push = accept && (entry.first_valid || entry.unterm);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         acc_ff    <= 21'd0;
         remain_ff <= 3'd0;
         min_ff    <= 17'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
         min_ff    <= min_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_queue.sv
module jsu_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jsu_pkg::entry_type        push_entry,
   input  logic                      pop,
   output jsu_pkg::entry_type        head,
   output jsu_pkg::queue_status_type status
);
   import jsu_pkg::*;

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/jsu_back.sv
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::entry_type head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jsu_pkg::rsp_type   rsp_data
);
   import jsu_pkg::*;

   logic phase_ff, phase_in;
   logic two_part;
   logic fire;
   logic more;

   assign two_part  = head.first_valid && head.unterm;
   assign more      = two_part && !phase_ff;
   assign rsp_valid = head_valid;
   assign rsp_data  = (head.first_valid && !phase_ff) ? head.first : UNTERM_RSP;
   assign fire      = rsp_valid && rsp_ready;
   assign pop       = fire && !more;
   assign phase_in  = fire ? more : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hw/rtl/json_string_utf8_unescape_top.sv
// JSON string body decoder: takes one byte per cycle of a string body
// (after the opening quote) and returns one word per decoded code point,
// a close word on the unescaped quote, or an error word; a byte marked
// last_byte that leaves the string open adds an unterminated error word.
// Bytes are accepted back to back, one per cycle, as long as the 4-entry
// result queue has room; each entry holds the one or two words of one byte,
// and bytes that give no word take no entry. The decoder state updates in
// the accepting cycle and its result is registered in the queue and offered
// on rsp from the queue head. The result port sends one word per cycle
// while rsp_ready is high, so a byte giving two words occupies it for both,
// and a stalled rsp side fills the queue before req_ready drops.
module json_string_utf8_unescape_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic             accept;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .entry    (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (status.not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/jsu_checker.sv
`include "json_string_utf8_unescape_top_assert.svh"

module jsu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input jsu_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   `JSU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && req_ready), "queue not empty after reset")
   `JSU_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled word changed")
   `JSU_ASSERT(a_char_word, clock, reset, (rsp_valid && rsp_data.kind == KIND_CHAR) |-> (!rsp_data.final_flag && rsp_data.error_code == ERR_ESCAPE), "character word marked final")
   `JSU_ASSERT(a_final_word, clock, reset, (rsp_valid && rsp_data.kind != KIND_CHAR) |-> (rsp_data.final_flag && rsp_data.code_point == 21'd0), "close or error word not final")

endmodule

bind json_string_utf8_unescape_top jsu_checker u_checker (.*);
